@@ rtl/rims_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rims_pkg: shared types and constants for the run insertion merge sorter.
// Holds the default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package rims_pkg;

   localparam int unsigned MaxItemsDefault = 64;
   localparam int unsigned RunLenDefault   = 16;
   localparam int unsigned DataBitsDefault = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INS_NEXT,
      ST_INS_GETW,
      ST_INS_CMP,
      ST_INS_PLACE,
      ST_MRG_PAIR,
      ST_MRG_TOP,
      ST_MRG_GETA,
      ST_MRG_CMP,
      ST_MRG_TAIL,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_OUT_RD,
      ST_OUT_HOLD
   } state_type;

   // Signed compare of two words: true when a is above b.
   function automatic logic word_gt(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
      return a > b;
   endfunction

endpackage
`default_nettype wire

@@ rtl/rims_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rims_mem: simple dual port memory.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rims_mem #(
   parameter int unsigned Depth = 64,
   parameter int unsigned Width = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/run_insertion_merge_sorter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// run_insertion_merge_sorter_unit: load, sort and stream out signed words.
// Runs are insertion sorted in place, then merged bottom-up through a
// scratch memory and copied back, then streamed out in ascending order.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports
//  req     | in        | req_valid, req_ready, req_value, req_last
//  rsp     | out       | rsp_valid, rsp_ready, rsp_sorted_value, rsp_last_out,
//          |           | rsp_overflow
//
// Loading takes one word per cycle. Insertion shifts larger words of a run
// up one place at a time. A merge writes the lower head of each pair of runs
// to scratch, then the tail of the run that is left, and copies the pair back.
// Output reads each word and then holds it for the receiver. Every step is
// paced by the single registered read port of each memory. Reset is
// synchronous and clears only the control state. No word is taken while the
// block sorts or streams out; a stalled result holds in its output register.
module run_insertion_merge_sorter_unit #(
   parameter int unsigned MAX_ITEMS = rims_pkg::MaxItemsDefault,
   parameter int unsigned RUN_LEN   = rims_pkg::RunLenDefault,
   parameter int unsigned DATA_BITS = rims_pkg::DataBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [DATA_BITS-1:0] req_value,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DATA_BITS-1:0]      rsp_sorted_value,
   output logic                      rsp_last_out,
   output logic                      rsp_overflow
);
   import rims_pkg::*;

   localparam int unsigned AW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
   // Counters must reach twice the capacity for merge bounds.
   localparam int unsigned PW = $clog2(2 * MAX_ITEMS + RUN_LEN + 1) + 1;
   localparam logic [PW-1:0] RunLenP = PW'(RUN_LEN);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [PW-1:0] lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in, j_ff, j_in;
   logic [PW-1:0] mid_ff, mid_in, a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [PW-1:0] width_ff, width_in;
   logic [DATA_BITS-1:0] w_ff, w_in, va_ff, va_in;
   logic          ovalid_ff, ovalid_in, olast_ff, olast_in, oflow_ff, oflow_in;
   logic [DATA_BITS-1:0] odata_ff, odata_in;

   logic          e_we, s_we;
   logic [AW-1:0] e_wa, e_ra, s_wa, s_ra;
   logic [DATA_BITS-1:0] e_wd, e_rd, s_wd, s_rd;
   logic [PW-1:0] n_p;

   rims_mem #(.Depth(MAX_ITEMS), .Width(DATA_BITS)) u_elem (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));

   rims_mem #(.Depth(MAX_ITEMS), .Width(DATA_BITS)) u_scr (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));

   assign n_p = PW'(count_ff);
   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = ovalid_ff;
   assign rsp_sorted_value = odata_ff;
   assign rsp_last_out = olast_ff;
   assign rsp_overflow = oflow_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; i_ff <= i_in; j_ff <= j_in;
      mid_ff <= mid_in; a_ff <= a_in; b_ff <= b_in; k_ff <= k_in;
      width_ff <= width_in; w_ff <= w_in; va_ff <= va_in;
      olast_ff <= olast_in; oflow_ff <= oflow_in; odata_ff <= odata_in;
   end

   // Sequencer: next state, memory accesses and output register.
   always_comb begin
      logic [PW-1:0] t_hi;
      logic signed [63:0] x_rd, x_w, x_va;
      state_in = state_ff; count_in = count_ff; drop_in = drop_ff;
      lo_in = lo_ff; hi_in = hi_ff; i_in = i_ff; j_in = j_ff; mid_in = mid_ff;
      a_in = a_ff; b_in = b_ff; k_in = k_ff; width_in = width_ff;
      w_in = w_ff; va_in = va_ff;
      ovalid_in = ovalid_ff; olast_in = olast_ff; oflow_in = oflow_ff;
      odata_in = odata_ff;
      e_we = 1'b0; e_wa = '0; e_wd = req_value; e_ra = '0;
      s_we = 1'b0; s_wa = AW'(k_ff); s_wd = e_rd; s_ra = '0;
      t_hi = '0;
      x_rd = 64'(signed'(e_rd));
      x_w  = 64'(signed'(w_ff));
      x_va = 64'(signed'(va_ff));
      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  e_we = 1'b1; e_wa = AW'(count_ff);
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  // Start insertion at the first run; i begins at lo+1.
                  t_hi = (RunLenP < PW'(count_in)) ? RunLenP : PW'(count_in);
                  lo_in = '0; hi_in = t_hi; i_in = PW'(1);
                  state_in = ST_INS_NEXT;
               end
            end
         end
         ST_INS_NEXT: begin
            if (i_ff >= hi_ff) begin
               // Run done, go to the next run or to merging.
               if (hi_ff >= n_p) begin
                  width_in = RunLenP; lo_in = '0; state_in = ST_MRG_PAIR;
               end else begin
                  lo_in = hi_ff;
                  hi_in = (hi_ff + RunLenP < n_p) ? hi_ff + RunLenP : n_p;
                  i_in = hi_ff + 1'b1;
               end
            end else begin
               // Fetch the word to insert.
               e_ra = AW'(i_ff); state_in = ST_INS_GETW;
            end
         end
         ST_INS_GETW: begin
            w_in = e_rd; j_in = i_ff;
            e_ra = AW'(i_ff - 1'b1);
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            // e_rd holds the word at j-1; shift it up while it is above w.
            e_we = 1'b1; e_wa = AW'(j_ff);
            if (word_gt(x_rd, x_w)) begin
               e_wd = e_rd;
               j_in = j_ff - 1'b1;
               if (j_ff - 1'b1 == lo_ff) begin
                  state_in = ST_INS_PLACE;
               end else begin
                  e_ra = AW'(j_ff - PW'(2));
               end
            end else begin
               e_wd = w_ff;
               i_in = i_ff + 1'b1; state_in = ST_INS_NEXT;
            end
         end
         ST_INS_PLACE: begin
            // The word goes to the start of its run.
            e_we = 1'b1; e_wa = AW'(lo_ff); e_wd = w_ff;
            i_in = i_ff + 1'b1; state_in = ST_INS_NEXT;
         end
         ST_MRG_PAIR: begin
            // Set up the next pair of this pass, the next pass, or output.
            if (lo_ff + width_ff < n_p) begin
               mid_in = lo_ff + width_ff;
               hi_in = (lo_ff + (width_ff << 1) < n_p) ? lo_ff + (width_ff << 1)
                                                         : n_p;
               a_in = lo_ff; b_in = lo_ff + width_ff; k_in = lo_ff;
               state_in = ST_MRG_TOP;
            end else if ((width_ff << 1) < n_p) begin
               width_in = width_ff << 1; lo_in = '0;
            end else begin
               k_in = '0; state_in = ST_OUT_RD;
            end
         end
         ST_MRG_TOP: begin
            if (a_ff < mid_ff && b_ff < hi_ff) begin
               e_ra = AW'(a_ff); state_in = ST_MRG_GETA;
            end else if (a_ff < mid_ff) begin
               e_ra = AW'(a_ff); a_in = a_ff + 1'b1; state_in = ST_MRG_TAIL;
            end else if (b_ff < hi_ff) begin
               e_ra = AW'(b_ff); b_in = b_ff + 1'b1; state_in = ST_MRG_TAIL;
            end else begin
               k_in = lo_ff; state_in = ST_COPY_RD;
            end
         end
         ST_MRG_GETA: begin
            va_in = e_rd; e_ra = AW'(b_ff); state_in = ST_MRG_CMP;
         end
         ST_MRG_CMP: begin
            // va is the left head, e_rd the right head; left wins on ties.
            s_we = 1'b1; k_in = k_ff + 1'b1; state_in = ST_MRG_TOP;
            if (word_gt(x_va, x_rd)) begin
               s_wd = e_rd; b_in = b_ff + 1'b1;
            end else begin
               s_wd = va_ff; a_in = a_ff + 1'b1;
            end
         end
         ST_MRG_TAIL: begin
            s_we = 1'b1; k_in = k_ff + 1'b1; state_in = ST_MRG_TOP;
         end
         ST_COPY_RD: begin
            if (k_ff >= hi_ff) begin
               lo_in = hi_ff; state_in = ST_MRG_PAIR;
            end else begin
               s_ra = AW'(k_ff); state_in = ST_COPY_WR;
            end
         end
         ST_COPY_WR: begin
            e_we = 1'b1; e_wa = AW'(k_ff); e_wd = s_rd;
            k_in = k_ff + 1'b1; state_in = ST_COPY_RD;
         end
         ST_OUT_RD: begin
            if (k_ff >= n_p) begin
               count_in = '0; drop_in = 1'b0; state_in = ST_LOAD;
            end else if (!ovalid_ff || rsp_ready) begin
               e_ra = AW'(k_ff); state_in = ST_OUT_HOLD;
            end
         end
         ST_OUT_HOLD: begin
            ovalid_in = 1'b1; odata_in = e_rd;
            olast_in = (k_ff + 1'b1 == n_p); oflow_in = drop_ff;
            k_in = k_ff + 1'b1; state_in = ST_OUT_RD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule
`default_nettype wire

@@ sim/tb_run_insertion_merge_sorter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_run_insertion_merge_sorter_unit: self-checking bench for the sorter.
// Sets of signed words are streamed in. A local model sorts each finished
// set, and every sorted word that comes out is checked in order against it.
// Sets cover single words, duplicates, extremes, run and merge boundaries
// and overflow past capacity, under random and long output stalls.
// ----------------------------------------------------------------------------
module tb_run_insertion_merge_sorter_unit;
   import rims_pkg::*;

   localparam int unsigned Capacity = MaxItemsDefault;
   localparam int unsigned WordBits = DataBitsDefault;

   typedef logic signed [WordBits-1:0] word_type;
   typedef struct {
      word_type value;
      logic     last_out;
      logic     overflow;
   } sorted_word_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_value = '0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   logic [WordBits-1:0] rsp_sorted_value;
   logic     rsp_last_out;
   logic     rsp_overflow;

   // Model state: words held for the current set and the drop flag.
   word_type        held_words[$];
   logic            words_dropped = 1'b0;
   sorted_word_type pending_sorted[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;
   int mismatches    = 0;

   run_insertion_merge_sorter_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Absolute limit on the run.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Take in one word; on the final word sort the set and queue the results.
   function automatic void load_word(input word_type value, input logic last);
      word_type        sorted[$];
      word_type        w;
      sorted_word_type item;
      int              j;
      if (held_words.size() < Capacity) held_words = {held_words, value};
      else words_dropped = 1'b1;
      if (!last) return;
      sorted = held_words;
      for (int i = 1; i < sorted.size(); i++) begin
         w = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > w) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = w;
      end
      foreach (sorted[k]) begin
         item.value    = sorted[k];
         item.last_out = (k == sorted.size() - 1);
         item.overflow = words_dropped;
         pending_sorted = {pending_sorted, item};
      end
      held_words.delete();
      words_dropped = 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [WordBits-1:0] got,
                                  input logic [WordBits-1:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Receiver: random or forced hold-off of the result channel.
   always @(posedge clock) begin
      if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check every result transfer against the oldest sorted word.
   always @(posedge clock) begin
      sorted_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sorted.size() == 0) begin
            report_mismatch("unexpected result", rsp_sorted_value, '0);
         end else begin
            want = pending_sorted[0];
            pending_sorted.delete(0);
            if (rsp_sorted_value !== want.value)
               report_mismatch("sorted_value", rsp_sorted_value, want.value);
            if (rsp_last_out !== want.last_out)
               report_mismatch("last_out", rsp_last_out, want.last_out);
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", rsp_overflow, want.overflow);
         end
      end
   end

   // Send one word; valid stays high between back-to-back transfers.
   task automatic send_word(input word_type value, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      load_word(value, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_sorted.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic word_type pick_value();
      case ($urandom_range(9))
         0: return {1'b1, {(WordBits-1){1'b0}}};
         1: return {1'b0, {(WordBits-1){1'b1}}};
         2, 3: return word_type'($signed($urandom_range(6)) - 3);
         default: return word_type'($urandom());
      endcase
   endfunction

   task automatic send_set(input int count);
      for (int i = 0; i < count; i++) send_word(pick_value(), i == count - 1);
   endtask

   // Extremes, single word, duplicates, a reversed set across a run boundary.
   task automatic test_directed();
      word_type min_w, max_w;
      min_w = {1'b1, {(WordBits-1){1'b0}}};
      max_w = {1'b0, {(WordBits-1){1'b1}}};
      send_word(max_w, 1'b1);
      send_word(max_w, 1'b0);
      send_word(min_w, 1'b1);
      send_word(-1, 1'b0);
      send_word(0, 1'b0);
      send_word(-1, 1'b0);
      send_word(0, 1'b1);
      for (int i = 0; i < 17; i++) send_word(word_type'(8 - i), i == 16);
      drain();
   endtask

   // Full store without drop, then one past capacity so the last is dropped.
   task automatic test_overflow();
      send_set(Capacity);
      send_set(Capacity + 1);
      drain();
   endtask

   // Long output hold-off while the sender keeps offering words.
   task automatic test_backpressure();
      @(posedge clock);
      stall_cycles = 600;
      send_set(30);
      send_set(12);
      drain();
   endtask

   // Random sets, mostly small, some near or past capacity.
   task automatic test_random(input int items, input int s_idle, input int r_idle);
      int sent, size, pick;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 70) size = $urandom_range(16, 1);
         else if (pick < 92) size = $urandom_range(40, 17);
         else size = $urandom_range(Capacity + 4, Capacity - 4);
         send_set(size);
         sent += size;
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 17;
      recv_idle_pct = 67;
      test_directed();
      test_overflow();
      test_backpressure();
      test_random(25, 17, 67);
      test_random(25, 67, 17);
      test_random(25, 0, 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_sorted.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
